FILE: rtl/core/bps_pkg.sv
// shared constants and types for the board power sequencer
`default_nettype none

package bps_pkg;

  // stream payload widths (padded to whole bytes)
  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 16;

  // config bus
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [0:0]  REG_SETTLE = 1'b0;

  // phase codes
  localparam logic [2:0] PH_STANDBY = 3'd0;
  localparam logic [2:0] PH_12V     = 3'd1;
  localparam logic [2:0] PH_CORE    = 3'd2;
  localparam logic [2:0] PH_IO      = 3'd3;
  localparam logic [2:0] PH_RUN     = 3'd4;

  localparam logic [7:0] SETTLE_RESET = 8'd20;
  localparam logic [7:0] COUNT_MAX    = 8'hff;

  // result beat, last field in the lowest bit
  typedef struct packed {
    logic [2:0] phase_now;
    logic       fault_lamp;
    logic       power_lamp;
    logic       enable_core;
    logic       enable_3v3;
    logic       enable_5v;
    logic       enable_12v;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/board_power_sequencer.sv
// board power sequencer: rail enable phases driven by sample ticks
`default_nettype none

// One input beat is one sample tick carrying the button level and the four
// power-good levels; every tick gives exactly one result beat with the rail
// enables, the two lamps and the phase after the tick. The phase logic sits
// between the state registers and a single output register, and a new tick
// is taken every cycle while the output register is empty or being drained.
// settle_ticks (address 0) sets how many ticks the IO-on phase lasts before
// run; 0 acts as 1.
module board_power_sequencer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // s_tdata: button_level, good_12v, good_5v, good_3v3, good_core, pad
  input  wire logic [bps_pkg::IN_W-1:0]    s_tdata,
  // output stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // m_tdata: enable_12v, enable_5v, enable_3v3, enable_core, power_lamp,
  //          fault_lamp, phase_now[2:0], pad
  output logic [bps_pkg::OUT_W-1:0]        m_tdata,
  // config port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bps_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bps_pkg::DATA_W-1:0]  pwdata,
  output logic [bps_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import bps_pkg::*;

  logic [7:0] settle_ticks;
  logic [2:0] phase, phase_next;
  logic       button_prev;
  logic       press_pending, press_pending_next;
  logic [7:0] settle_count, settle_count_next;
  logic       fault_mark, fault_mark_next;
  result_t    res_next;
  result_t    res;
  logic       in_acc;
  logic       cfg_wr;
  logic       btn, g12, g5, g33, gcore;
  logic       press, all_good;
  logic [7:0] count_inc;

  // config register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SETTLE) ? {{(DATA_W-8){1'b0}}, settle_ticks}
                                           : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= SETTLE_RESET;
    end else if (cfg_wr && paddr[2] == REG_SETTLE) begin
      settle_ticks <= pwdata[7:0];
    end
  end

  // beat handshake, output register parts the two sides
  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  assign btn   = s_tdata[0];
  assign g12   = s_tdata[1];
  assign g5    = s_tdata[2];
  assign g33   = s_tdata[3];
  assign gcore = s_tdata[4];

  assign press     = press_pending || (btn && !button_prev);
  assign all_good  = g12 && g5 && g33 && gcore;
  assign count_inc = (settle_count == COUNT_MAX) ? settle_count : settle_count + 8'd1;

  // phase step for the phase in force at the start of the tick
  always_comb begin
    phase_next         = phase;
    press_pending_next = press;
    settle_count_next  = settle_count;
    fault_mark_next    = fault_mark;
    res_next           = '0;
    case (phase)
      PH_12V: begin
        res_next.enable_12v = 1'b1;
        if (g12) phase_next = PH_CORE;
      end
      PH_CORE: begin
        res_next.enable_12v  = 1'b1;
        res_next.enable_core = 1'b1;
        if (gcore) begin
          phase_next        = PH_IO;
          settle_count_next = '0;
        end
      end
      PH_IO: begin
        res_next.enable_12v  = 1'b1;
        res_next.enable_core = 1'b1;
        res_next.enable_5v   = 1'b1;
        res_next.enable_3v3  = 1'b1;
        settle_count_next    = count_inc;
        if (count_inc >= settle_ticks) begin
          phase_next        = PH_RUN;
          settle_count_next = '0;
        end
      end
      PH_RUN: begin
        res_next.enable_12v  = 1'b1;
        res_next.enable_core = 1'b1;
        res_next.enable_5v   = 1'b1;
        res_next.enable_3v3  = 1'b1;
        res_next.power_lamp  = all_good;
        fault_mark_next      = !all_good;
        if (!all_good || press) phase_next = PH_STANDBY;
        if (press) press_pending_next = 1'b0;
      end
      default: begin
        // standby, and unused codes behave the same
        phase_next        = PH_STANDBY;
        settle_count_next = '0;
        if (press) begin
          phase_next         = PH_12V;
          press_pending_next = 1'b0;
          fault_mark_next    = 1'b0;
        end
      end
    endcase
    res_next.fault_lamp = fault_mark_next;
    res_next.phase_now  = phase_next;
  end

  // sequencer state, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_STANDBY;
      button_prev   <= 1'b0;
      press_pending <= 1'b0;
      settle_count  <= '0;
      fault_mark    <= 1'b0;
    end else if (in_acc) begin
      phase         <= phase_next;
      button_prev   <= btn;
      press_pending <= press_pending_next;
      settle_count  <= settle_count_next;
      fault_mark    <= fault_mark_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(OUT_W-$bits(result_t)){1'b0}}, res};

  // checks
  a_lamp_no_fault: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.power_lamp) |-> !res.fault_lamp)
    else $error("power lamp lit together with fault lamp");

  a_rail_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.enable_5v || res.enable_3v3)) |->
      (res.enable_core && res.enable_12v))
    else $error("io rails enabled ahead of core or 12v");

  a_count_only_io: assert property (@(posedge clk) disable iff (rst)
    (settle_count != 8'd0) |-> (phase == PH_IO))
    else $error("settle count held outside io-on phase");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(phase))
    else $error("phase moved without a tick");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> m_tvalid)
    else $error("accepted tick gave no result beat");

endmodule

`default_nettype wire

FILE: tb/tb_board_power_sequencer.sv
// self-checking testbench for the board power sequencer stream and config port
module tb_board_power_sequencer;
  import bps_pkg::*;

  // index of the register slot past settle_ticks, decoded by nothing
  localparam logic [0:0] SPARE_REG = 1'b1;
  localparam int unsigned RUN_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // s_tdata: button_level, good_12v, good_5v, good_3v3, good_core, pad
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // m_tdata: enable_12v, enable_5v, enable_3v3, enable_core, power_lamp,
  //          fault_lamp, phase_now[2:0], pad
  logic [OUT_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // stimulus knobs for the driving processes
  bit calm = 1'b0;
  bit long_stall = 1'b0;
  int gap_div = 4;
  logic btn_lvl = 1'b0;

  // tracks the sequencer state and holds the status beats still due
  class rail_tracker;
    logic [7:0] settle_len = SETTLE_RESET;
    logic [2:0] cur_phase = PH_STANDBY;
    logic btn_last = 1'b0;
    logic press_latched = 1'b0;
    logic [7:0] settle_cnt = '0;
    logic fault_flag = 1'b0;
    result_t status_due[$];
    int miss_count = 0;
    int beat_count = 0;

    function void report(string msg);
      if (miss_count < 40) begin
        $display("mismatch at status beat %0d: %s", beat_count, msg);
      end
      miss_count++;
    endfunction

    function void config_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
      if (addr[ADDR_W-1:2] == REG_SETTLE) begin
        settle_len = val[7:0];
      end
    endfunction

    // one sample tick: button edge first, then the phase in force acts
    function void note_tick(logic [IN_W-1:0] beat);
      logic btn, ok_12v, ok_5v, ok_3v3, ok_core;
      result_t want;
      {ok_core, ok_3v3, ok_5v, ok_12v, btn} = beat[4:0];
      if (btn && !btn_last) begin
        press_latched = 1'b1;
      end
      btn_last = btn;
      want = '0;
      case (cur_phase)
        PH_12V: begin
          want.enable_12v = 1'b1;
          if (ok_12v) cur_phase = PH_CORE;
        end
        PH_CORE: begin
          want.enable_12v = 1'b1;
          want.enable_core = 1'b1;
          if (ok_core) begin
            cur_phase = PH_IO;
            settle_cnt = '0;
          end
        end
        PH_IO: begin
          {want.enable_12v, want.enable_5v, want.enable_3v3, want.enable_core} = 4'hf;
          if (settle_cnt != COUNT_MAX) settle_cnt++;
          if (settle_cnt >= settle_len) begin
            cur_phase = PH_RUN;
            settle_cnt = '0;
          end
        end
        PH_RUN: begin
          {want.enable_12v, want.enable_5v, want.enable_3v3, want.enable_core} = 4'hf;
          if (!(ok_12v && ok_5v && ok_3v3 && ok_core)) begin
            cur_phase = PH_STANDBY;
            fault_flag = 1'b1;
          end else begin
            want.power_lamp = 1'b1;
            fault_flag = 1'b0;
          end
          if (press_latched) begin
            cur_phase = PH_STANDBY;
            press_latched = 1'b0;
          end
        end
        default: begin
          cur_phase = PH_STANDBY;
          settle_cnt = '0;
          if (press_latched) begin
            cur_phase = PH_12V;
            press_latched = 1'b0;
            fault_flag = 1'b0;
          end
        end
      endcase
      want.fault_lamp = fault_flag;
      want.phase_now = cur_phase;
      status_due.push_back(want);
    endfunction

    // compare one status beat with the oldest one due
    function void check_status(logic [OUT_W-1:0] beat);
      result_t got, want;
      got = beat[$bits(result_t)-1:0];
      beat_count++;
      if (status_due.size() == 0) begin
        report("status beat with nothing due");
        return;
      end
      want = status_due.pop_front();
      if (got.enable_12v !== want.enable_12v)
        report($sformatf("enable_12v got %b want %b", got.enable_12v, want.enable_12v));
      if (got.enable_5v !== want.enable_5v)
        report($sformatf("enable_5v got %b want %b", got.enable_5v, want.enable_5v));
      if (got.enable_3v3 !== want.enable_3v3)
        report($sformatf("enable_3v3 got %b want %b", got.enable_3v3, want.enable_3v3));
      if (got.enable_core !== want.enable_core)
        report($sformatf("enable_core got %b want %b", got.enable_core, want.enable_core));
      if (got.power_lamp !== want.power_lamp)
        report($sformatf("power_lamp got %b want %b", got.power_lamp, want.power_lamp));
      if (got.fault_lamp !== want.fault_lamp)
        report($sformatf("fault_lamp got %b want %b", got.fault_lamp, want.fault_lamp));
      if (got.phase_now !== want.phase_now)
        report($sformatf("phase_now got %0d want %0d", got.phase_now, want.phase_now));
    endfunction
  endclass

  rail_tracker sb;

  board_power_sequencer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitor on both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_tick(s_tdata);
      if (m_tvalid && m_tready) sb.check_status(m_tdata);
    end
  end

  // receiver: ready bursts, stall bursts and one long hold-off
  initial begin
    forever begin
      if (long_stall) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
        long_stall = 1'b0;
      end else if (calm || $urandom_range(3) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // run guard
  initial begin
    #RUN_LIMIT;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [IN_W-1:0] pack_tick(logic btn, logic g12, logic g5,
                                                logic g33, logic gcore);
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[4:0] = {gcore, g33, g5, g12, btn};
    return beat;
  endfunction

  // offer one tick beat, after an optional idle burst
  task automatic send_tick(input logic [IN_W-1:0] beat);
    int gap;
    gap = 0;
    if (!calm && gap_div != 0 && $urandom_range(gap_div - 1) == 0) begin
      gap = $urandom_range(1, 17);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= beat;
    do @(posedge clk); while (!s_tready);
  endtask

  // drain every status beat due, then let the output register settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // two-phase register write
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.config_write(addr, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random ticks in segments: button chatter rate, rail dropout rate, gaps
  task automatic run_ticks(input int count);
    int i, j, toggle_div, fail_div;
    logic [3:0] good_bits;
    toggle_div = 8;
    fail_div = 0;
    for (i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        toggle_div = $urandom_range(2, 40);
        case ($urandom_range(3))
          0, 1: fail_div = 0;
          2: fail_div = 12;
          default: fail_div = 2;
        endcase
        gap_div = $urandom_range(0, 6);
      end
      if ($urandom_range(toggle_div - 1) == 0) btn_lvl = ~btn_lvl;
      good_bits = 4'hf;
      if (fail_div != 0) begin
        for (j = 0; j < 4; j++) begin
          if ($urandom_range(fail_div - 1) == 0) good_bits[j] = 1'b0;
        end
      end
      // occasional raw noise tick
      if ($urandom_range(19) == 0) {good_bits, btn_lvl} = 5'($urandom);
      send_tick(pack_tick(btn_lvl, good_bits[0], good_bits[1], good_bits[2],
                          good_bits[3]));
    end
  endtask

  // main sequence
  initial begin
    int wait_cnt;
    sb = new;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // start-up at the reset settle length: press, hold, wait on rails
    send_tick(pack_tick(0, 0, 0, 0, 0));
    send_tick(pack_tick(1, 0, 0, 0, 0));
    send_tick(pack_tick(1, 0, 0, 0, 0));
    send_tick(pack_tick(0, 0, 1, 1, 1));
    // press while ramping stays latched through IO on
    send_tick(pack_tick(1, 1, 0, 0, 0));
    send_tick(pack_tick(0, 1, 1, 1, 0));
    send_tick(pack_tick(0, 0, 0, 0, 1));
    run_ticks(90);

    // shortest settle, steer back to standby with good rails and presses
    wait_idle();
    write_reg({REG_SETTLE, 2'b00}, 32'd1);
    while (sb.cur_phase != PH_STANDBY) begin
      send_tick(pack_tick(~sb.btn_last, 1, 1, 1, 1));
      wait_idle();
    end
    send_tick(pack_tick(0, 1, 1, 1, 1));
    send_tick(pack_tick(1, 1, 1, 1, 1));
    repeat (3) send_tick(pack_tick(0, 1, 1, 1, 1));
    // run with all rails good, then a 5v dropout
    send_tick(pack_tick(0, 1, 1, 1, 1));
    send_tick(pack_tick(0, 1, 0, 1, 1));
    // press clears the fault lamp on the way up
    send_tick(pack_tick(1, 1, 1, 1, 1));
    repeat (3) send_tick(pack_tick(0, 1, 1, 1, 1));
    // fault and press in the same run tick
    send_tick(pack_tick(1, 0, 1, 1, 1));
    send_tick(pack_tick(0, 1, 1, 1, 1));
    send_tick(pack_tick(1, 1, 1, 1, 1));
    repeat (3) send_tick(pack_tick(0, 1, 1, 1, 1));
    // clean power-down press in run
    send_tick(pack_tick(1, 1, 1, 1, 1));

    // write to the unused slot must leave settle_ticks alone
    wait_idle();
    write_reg({SPARE_REG, 2'b00}, 32'h0000_0007);
    run_ticks(100);

    // longest settle
    wait_idle();
    write_reg({REG_SETTLE, 2'b00}, 32'h0000_00ff);
    run_ticks(280);

    // zero settle acts as one; receiver holds off so the block backs up
    wait_idle();
    write_reg({REG_SETTLE, 2'b00}, 32'h0000_0000);
    long_stall = 1'b1;
    run_ticks(80);

    // small settle with junk in the upper data bits
    wait_idle();
    write_reg({REG_SETTLE, 2'b00}, {24'ha5a5a5, 8'($urandom_range(2, 12))});
    run_ticks(80);

    wait_idle();
    write_reg({REG_SETTLE, 2'b00}, 32'($urandom_range(1, 255)));
    run_ticks(80);

    // last stretch with no idling on either side
    wait_idle();
    write_reg({REG_SETTLE, 2'b00}, 32'($urandom_range(1, 6)));
    calm = 1'b1;
    run_ticks(80);

    // drain and finish
    s_tvalid <= 1'b0;
    @(posedge clk);
    for (wait_cnt = 0; wait_cnt < 2000 && sb.status_due.size() != 0; wait_cnt++) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (sb.status_due.size() != 0) begin
      sb.report($sformatf("%0d status beats never arrived", sb.status_due.size()));
    end
    if (sb.miss_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
